// ===== rtl/core/adsr_pkg.sv =====
// adsr_pkg: shared types and constants for the linear adsr envelope generator
// used by adsr_div and adsr_envelope_generator_unit; no dependencies
package adsr_pkg;

   localparam int TIME_BITS   = 32;
   localparam int LEVEL_BITS  = 16;
   localparam int PROD_BITS   = TIME_BITS + LEVEL_BITS;
   localparam int CNT_BITS    = $clog2(PROD_BITS);
   localparam int CSR_IDX_BITS = 3;

   localparam logic [LEVEL_BITS-1:0] LEVEL_MAX = '1;
   // levels at or below this are squelched to zero
   localparam logic [LEVEL_BITS-1:0] LEVEL_FLOOR =
      LEVEL_BITS'(((1 << LEVEL_BITS) - 1) / 10000);

   typedef enum logic [1:0] {
      OP_QUERY    = 2'd0,
      OP_NOTE_ON  = 2'd1,
      OP_NOTE_OFF = 2'd2,
      OP_UNUSED   = 2'd3
   } op_type;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      REG_ENABLED = 3'd0,
      REG_START   = 3'd1,
      REG_ATTACK  = 3'd2,
      REG_DECAY   = 3'd3,
      REG_SUSTAIN = 3'd4,
      REG_RELEASE = 3'd5
   } csr_reg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_PHASE,
      ST_PICK,
      ST_MUL,
      ST_DIV,
      ST_FIN,
      ST_DONE
   } state_type;

   typedef enum logic [2:0] {
      MODE_ATTACK,
      MODE_DEC_UP,
      MODE_DEC_DOWN,
      MODE_REL_DOWN,
      MODE_REL_UP,
      MODE_HOLD
   } mode_type;

   typedef struct packed {
      logic accept;
      logic eval;
      logic phase;
      logic pick;
      logic div_start;
      logic fin;
      logic out_load;
   } seq_ctrl_type;

endpackage

// ===== rtl/core/adsr_div.sv =====
// adsr_div: restoring divider, one quotient bit per cycle
// depends on adsr_pkg for the operand widths
module adsr_div
   import adsr_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [PROD_BITS-1:0] dividend,
   input  logic [TIME_BITS-1:0] divisor,
   output logic                 done,
   output logic [PROD_BITS-1:0] quotient
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic [PROD_BITS-1:0] dvd_ff, dvd_in;
   logic [TIME_BITS-1:0] rem_ff, rem_in;
   logic [TIME_BITS-1:0] dsr_ff, dsr_in;
   logic [TIME_BITS:0]   rem_sh;
   logic [TIME_BITS:0]   rem_sub;
   logic                 fits;

   assign rem_sh  = {rem_ff, dvd_ff[PROD_BITS-1]};
   assign rem_sub = rem_sh - {1'b0, dsr_ff};
   assign fits    = rem_sh >= {1'b0, dsr_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_BITS'(PROD_BITS - 1);
         dvd_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         // quotient bits shift in from the bottom as dividend bits leave the top
         dvd_in = {dvd_ff[PROD_BITS-2:0], fits};
         rem_in = fits ? rem_sub[TIME_BITS-1:0] : rem_sh[TIME_BITS-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = dvd_ff;

endmodule

// ===== rtl/core/adsr_envelope_generator_unit.sv =====
// adsr_envelope_generator_unit: linear adsr envelope, top level; needs adsr_pkg, adsr_div
// sequence: a ramp query runs accept, EVAL, PHASE, PICK (decay only), MUL, the 48-step
//   shared divider, FIN and DONE into the output register; note events and disabled
//   queries go from EVAL to DONE, and flat or zero levels leave the divider out
// throughput: one item at a time, the next is accepted the cycle after the result is
//   loaded and a stalled result holds the block; reset clears control, CSR and note state
module adsr_envelope_generator_unit
   import adsr_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [1:0]              req_op,
   input  logic [TIME_BITS-1:0]    req_tick_time,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [LEVEL_BITS-1:0]   rsp_level,
   output logic                    rsp_status,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [TIME_BITS-1:0]    csr_wdata
);

   state_type             state_ff, state_in;
   seq_ctrl_type          ctrl;

   logic                  enabled_ff, enabled_in;
   logic [LEVEL_BITS-1:0] start_ff, start_in;
   logic [TIME_BITS-1:0]  attack_ff, attack_in;
   logic [TIME_BITS-1:0]  decay_ff, decay_in;
   logic [LEVEL_BITS-1:0] sustain_ff, sustain_in;
   logic [TIME_BITS-1:0]  release_ff, release_in;

   logic                  held_ff, held_in;
   logic [TIME_BITS-1:0]  on_time_ff, on_time_in;
   logic [TIME_BITS-1:0]  off_time_ff, off_time_in;

   op_type                op_ff, op_in;
   logic [TIME_BITS-1:0]  time_ff, time_in;
   logic                  neg_ff, neg_in;
   logic [TIME_BITS-1:0]  mag_ff, mag_in;
   logic [TIME_BITS-1:0]  x_ff, x_in;
   mode_type              mode_ff, mode_in;
   logic [LEVEL_BITS-1:0] mul_a_ff, mul_a_in;
   logic [TIME_BITS-1:0]  mul_b_ff, mul_b_in;
   logic [TIME_BITS-1:0]  dsr_ff, dsr_in;
   logic [LEVEL_BITS-1:0] level_ff, level_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [LEVEL_BITS-1:0] rsp_level_ff, rsp_level_in;
   logic                  rsp_status_ff, rsp_status_in;

   logic [TIME_BITS-1:0]  diff;
   logic                  in_attack;
   logic                  rel_zero;
   logic                  in_decay;
   logic                  cfg_wr;
   logic                  div_done;
   logic [PROD_BITS-1:0]  quo;
   logic [PROD_BITS-1:0]  product;
   logic [PROD_BITS:0]    rel_sum;
   logic [LEVEL_BITS-1:0] fin_level;

   assign csr_ready = 1'b1;
   assign cfg_wr    = csr_valid && csr_ready;
   assign req_stall = (state_ff != ST_IDLE);

   // phase decisions from registered elapsed time
   assign in_attack = (attack_ff != '0) && (mag_ff <= attack_ff);
   assign rel_zero  = (release_ff == '0) || (!neg_ff && (mag_ff > release_ff));
   assign in_decay  = (decay_ff != '0) && (x_ff <= decay_ff);

   assign product = PROD_BITS'(mul_a_ff) * PROD_BITS'(mul_b_ff);

   adsr_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (ctrl.div_start),
      .dividend (product),
      .divisor  (dsr_ff),
      .done     (div_done),
      .quotient (quo)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_EVAL;
         end
         ST_EVAL: begin
            if (enabled_ff && (op_ff == OP_QUERY)) state_in = ST_PHASE;
            else state_in = ST_DONE;
         end
         ST_PHASE: begin
            if (held_ff) begin
               if (neg_ff) state_in = ST_DONE;
               else if (in_attack) state_in = ST_MUL;
               else state_in = ST_PICK;
            end else begin
               if (rel_zero) state_in = ST_DONE;
               else state_in = ST_MUL;
            end
         end
         ST_PICK: begin
            if (in_decay) state_in = ST_MUL;
            else state_in = ST_FIN;
         end
         ST_MUL: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_done) state_in = ST_FIN;
         end
         ST_FIN: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) state_in = ST_IDLE;
         end
      endcase
   end

   // sequencer outputs
   always_comb begin
      ctrl = '0;
      unique case (state_ff)
         ST_IDLE:  ctrl.accept    = req_valid;
         ST_EVAL:  ctrl.eval      = 1'b1;
         ST_PHASE: ctrl.phase     = 1'b1;
         ST_PICK:  ctrl.pick      = 1'b1;
         ST_MUL:   ctrl.div_start = 1'b1;
         ST_DIV:   ctrl = '0;
         ST_FIN:   ctrl.fin       = 1'b1;
         ST_DONE:  ctrl.out_load  = !rsp_valid_ff || !rsp_stall;
      endcase
   end

   // final level from the quotient, or the sustain level when holding
   always_comb begin
      rel_sum   = (PROD_BITS + 1)'(sustain_ff) + {1'b0, quo};
      fin_level = sustain_ff;
      unique case (mode_ff)
         MODE_ATTACK:   fin_level = quo[LEVEL_BITS-1:0];
         MODE_DEC_UP:   fin_level = start_ff + quo[LEVEL_BITS-1:0];
         MODE_DEC_DOWN: fin_level = start_ff - quo[LEVEL_BITS-1:0];
         MODE_REL_DOWN: fin_level = sustain_ff - quo[LEVEL_BITS-1:0];
         MODE_REL_UP: begin
            if (rel_sum > (PROD_BITS + 1)'(LEVEL_MAX)) fin_level = LEVEL_MAX;
            else fin_level = rel_sum[LEVEL_BITS-1:0];
         end
         default: fin_level = sustain_ff;
      endcase
      if (fin_level <= LEVEL_FLOOR) fin_level = '0;
   end

   assign diff = time_ff - (held_ff ? on_time_ff : off_time_ff);

   // datapath next values
   always_comb begin
      enabled_in  = enabled_ff;
      start_in    = start_ff;
      attack_in   = attack_ff;
      decay_in    = decay_ff;
      sustain_in  = sustain_ff;
      release_in  = release_ff;
      held_in     = held_ff;
      on_time_in  = on_time_ff;
      off_time_in = off_time_ff;
      op_in       = op_ff;
      time_in     = time_ff;
      neg_in      = neg_ff;
      mag_in      = mag_ff;
      x_in        = x_ff;
      mode_in     = mode_ff;
      mul_a_in    = mul_a_ff;
      mul_b_in    = mul_b_ff;
      dsr_in      = dsr_ff;
      level_in    = level_ff;

      if (cfg_wr) begin
         unique case (csr_index)
            REG_ENABLED: begin
               enabled_in  = csr_wdata[0];
               held_in     = 1'b0;
               on_time_in  = '0;
               off_time_in = '0;
            end
            REG_START:   start_in   = csr_wdata[LEVEL_BITS-1:0];
            REG_ATTACK:  attack_in  = csr_wdata;
            REG_DECAY:   decay_in   = csr_wdata;
            REG_SUSTAIN: sustain_in = csr_wdata[LEVEL_BITS-1:0];
            REG_RELEASE: release_in = csr_wdata;
            default: ;
         endcase
      end

      if (ctrl.accept) begin
         op_in   = op_type'(req_op);
         time_in = req_tick_time;
      end

      if (ctrl.eval) begin
         neg_in   = diff[TIME_BITS-1];
         mag_in   = diff[TIME_BITS-1] ? (~diff + 1'b1) : diff;
         level_in = (!enabled_ff && (op_ff == OP_QUERY)) ? LEVEL_MAX : '0;
         if (enabled_ff) begin
            if (op_ff == OP_NOTE_ON) begin
               on_time_in = time_ff;
               held_in    = 1'b1;
            end else if (op_ff == OP_NOTE_OFF) begin
               off_time_in = time_ff;
               held_in     = 1'b0;
            end
         end
      end

      if (ctrl.phase) begin
         if (held_ff) begin
            mode_in  = MODE_ATTACK;
            mul_a_in = start_ff;
            mul_b_in = mag_ff;
            dsr_in   = attack_ff;
            // with no attack this is the whole elapsed time
            x_in     = mag_ff - attack_ff;
         end else begin
            mode_in  = neg_ff ? MODE_REL_UP : MODE_REL_DOWN;
            mul_a_in = sustain_ff;
            mul_b_in = mag_ff;
            dsr_in   = release_ff;
         end
      end

      if (ctrl.pick) begin
         if (in_decay) begin
            mode_in  = (sustain_ff >= start_ff) ? MODE_DEC_UP : MODE_DEC_DOWN;
            mul_a_in = (sustain_ff >= start_ff) ? (sustain_ff - start_ff)
                                                : (start_ff - sustain_ff);
            mul_b_in = x_ff;
            dsr_in   = decay_ff;
         end else begin
            mode_in = MODE_HOLD;
         end
      end

      if (ctrl.fin) level_in = fin_level;
   end

   // output register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_level_in  = rsp_level_ff;
      rsp_status_in = rsp_status_ff;
      if (ctrl.out_load) begin
         rsp_valid_in  = 1'b1;
         rsp_level_in  = level_ff;
         rsp_status_in = !enabled_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         enabled_ff   <= 1'b0;
         start_ff     <= '0;
         attack_ff    <= '0;
         decay_ff     <= '0;
         sustain_ff   <= '0;
         release_ff   <= '0;
         held_ff      <= 1'b0;
         on_time_ff   <= '0;
         off_time_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         enabled_ff   <= enabled_in;
         start_ff     <= start_in;
         attack_ff    <= attack_in;
         decay_ff     <= decay_in;
         sustain_ff   <= sustain_in;
         release_ff   <= release_in;
         held_ff      <= held_in;
         on_time_ff   <= on_time_in;
         off_time_ff  <= off_time_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      time_ff       <= time_in;
      neg_ff        <= neg_in;
      mag_ff        <= mag_in;
      x_ff          <= x_in;
      mode_ff       <= mode_in;
      mul_a_ff      <= mul_a_in;
      mul_b_ff      <= mul_b_in;
      dsr_ff        <= dsr_in;
      level_ff      <= level_in;
      rsp_level_ff  <= rsp_level_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_level  = rsp_level_ff;
   assign rsp_status = rsp_status_ff;

endmodule
